// File: hdl/pgw_pkg.sv
// Package for the four-level page-table walker.
// Holds store geometry, field widths, entry bit positions, register indexes, operation codes,
// stream widths and walk levels. No dependencies.
package pgw_pkg;

    // Table store geometry
    localparam int STORE_WORDS   = 4096;
    localparam int TABLE_ENTRIES = 512;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths
    localparam int WORD_W  = 64;
    localparam int VA_W    = 48;
    localparam int WIDX_W  = 12;
    localparam int PA_W    = 52;
    localparam int FRAME_W = PA_W - 12;
    localparam int ENTRY_W = FRAME_W + IDX_W;

    // Entry bit positions
    localparam int BIT_PRESENT    = 0;
    localparam int BIT_WRITABLE   = 1;
    localparam int BIT_HUGE       = 7;
    localparam int BIT_SW_TABLE   = 9;
    localparam int BIT_SW_MAPPING = 10;
    localparam int BIT_NO_EXEC    = 63;

    // Configuration register indexes
    localparam logic CFG_ROOT_FRAME = 1'b0;
    localparam logic CFG_ENABLE     = 1'b1;
    localparam int   ROOT_W         = 3;

    // Operation codes carried on the input tuser
    localparam logic OP_WALK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 120;

    // Walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

endpackage

// File: hdl/pgw_ram.sv
// Generic single-port RAM with registered read data.
// Used for the page-table store; no dependencies.
module pgw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/four_level_page_table_walker.sv
// Four-level page-table walker with a built-in table store.
// Depends on pgw_pkg (constants) and pgw_ram (table store memory).
//
// Channel   Dir  Handshake                      Contents
// s_axis    in   tvalid/tready                  tuser: operation; tdata: see port
// m_axis    out  tvalid/tready                  tuser: mapped;    tdata: see port
// cfg       in   i_cfg_we (no wait)             i_cfg_idx selects register, i_cfg_data
//
// A table write or a disabled walk goes from its input transfer through the result state
// to the output register; a walk first reads one table entry per level, at most four, as a
// chain of dependent reads through the single port of the store, which has registered read
// data.
// After reset the store is swept to zero, one word a cycle, all STORE_WORDS (4096) words;
// no input transfer is taken meanwhile, configuration writes are.
// The output register holds a finished result while the next item is taken in; a walk
// that finishes while that register is still full waits until it drains.
module four_level_page_table_walker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [pgw_pkg::ROOT_W-1:0]       i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // low to high: walk_va[47:0], word_index[59:48], word_data[123:60], zero pad
    input  logic [pgw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation (0 walk, 1 table write)
    input  logic                             s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // low to high: phys_addr[51:0], page_flags[115:52], zero pad
    output logic [pgw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // mapped
    output logic                             m_axis_tuser
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    localparam int AW = pgw_pkg::ADDR_W;
    localparam int WW = pgw_pkg::WORD_W;

    // Control state
    logic [1:0]                   r_state, n_state;
    logic [AW-1:0]                r_clr, n_clr;
    logic [1:0]                   r_level, n_level;
    logic                         r_rd_ok, n_rd_ok;
    logic                         r_out_valid, n_out_valid;
    logic [pgw_pkg::ROOT_W-1:0]   r_root;
    logic                         r_enabled;

    // Payload
    logic [pgw_pkg::VA_W-1:0]     r_va, n_va;
    logic [WW-1:0]                r_eff, n_eff;
    logic                         r_res_mapped, n_res_mapped;
    logic [pgw_pkg::PA_W-1:0]     r_res_pa, n_res_pa;
    logic [WW-1:0]                r_res_flags, n_res_flags;
    logic                         r_out_mapped, n_out_mapped;
    logic [pgw_pkg::PA_W-1:0]     r_out_pa, n_out_pa;
    logic [WW-1:0]                r_out_flags, n_out_flags;

    // Store port
    logic                         ram_en;
    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [WW-1:0]                ram_wdata;
    logic [WW-1:0]                ram_q;

    // Input fields
    logic [pgw_pkg::VA_W-1:0]     in_va;
    logic [pgw_pkg::WIDX_W-1:0]   in_widx;
    logic [WW-1:0]                in_wdata;
    logic                         in_xfer;
    logic                         out_free;

    assign in_va    = s_axis_tdata[pgw_pkg::VA_W-1:0];
    assign in_widx  = s_axis_tdata[pgw_pkg::VA_W +: pgw_pkg::WIDX_W];
    assign in_wdata = s_axis_tdata[pgw_pkg::VA_W + pgw_pkg::WIDX_W +: WW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    pgw_ram #(
        .WIDTH (WW),
        .DEPTH (pgw_pkg::STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // Next-state and store access
    always_comb begin
        logic [WW-1:0]                       entry;
        logic [WW-1:0]                       merged;
        logic [pgw_pkg::FRAME_W-1:0]         frame;
        logic [pgw_pkg::IDX_W-1:0]           idx;
        logic [pgw_pkg::ENTRY_W-1:0]         word;
        logic [pgw_pkg::ENTRY_W-1:0]         root_word;

        n_state      = r_state;
        n_clr        = r_clr;
        n_level      = r_level;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid;
        n_va         = r_va;
        n_eff        = r_eff;
        n_res_mapped = r_res_mapped;
        n_res_pa     = r_res_pa;
        n_res_flags  = r_res_flags;
        n_out_mapped = r_out_mapped;
        n_out_pa     = r_out_pa;
        n_out_flags  = r_out_flags;

        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_clr;
        ram_wdata = '0;

        entry  = r_rd_ok ? ram_q : '0;
        merged = entry;
        if (!r_eff[pgw_pkg::BIT_WRITABLE]) begin
            merged[pgw_pkg::BIT_WRITABLE] = 1'b0;
        end
        if (r_eff[pgw_pkg::BIT_NO_EXEC]) begin
            merged[pgw_pkg::BIT_NO_EXEC] = 1'b1;
        end
        if (r_level == pgw_pkg::LVL_PML4) begin
            merged = entry;
        end
        // clear the software-owned bits below the root level, so no result carries them
        merged[pgw_pkg::BIT_SW_TABLE]   = merged[pgw_pkg::BIT_SW_TABLE] &
                                          (r_level == pgw_pkg::LVL_PML4);
        merged[pgw_pkg::BIT_SW_MAPPING] = merged[pgw_pkg::BIT_SW_MAPPING] &
                                          (r_level == pgw_pkg::LVL_PML4);

        frame = entry[pgw_pkg::PA_W-1:12];
        case (r_level)
            pgw_pkg::LVL_PML4: idx = r_va[38:30];
            pgw_pkg::LVL_PDPT: idx = r_va[29:21];
            default:           idx = r_va[20:12];
        endcase
        word      = {frame, idx};
        root_word = {(pgw_pkg::FRAME_W)'(r_root), in_va[47:39]};

        // Drain the output register
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // sweep the store to zero after reset
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == AW'(pgw_pkg::STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_va         = in_va;
                    n_res_mapped = 1'b0;
                    n_res_pa     = '0;
                    n_res_flags  = '0;
                    n_level      = pgw_pkg::LVL_PML4;
                    if (s_axis_tuser == pgw_pkg::OP_WRITE) begin
                        // table write; drop writes beyond the store
                        ram_en    = (32'(in_widx) < 32'(pgw_pkg::STORE_WORDS));
                        ram_we    = 1'b1;
                        ram_addr  = AW'(in_widx);
                        ram_wdata = in_wdata;
                        n_state   = S_RESULT;
                    end else if (!r_enabled) begin
                        n_state = S_RESULT;
                    end else begin
                        ram_en   = 1'b1;
                        ram_addr = root_word[AW-1:0];
                        n_rd_ok  = (root_word < pgw_pkg::ENTRY_W'(pgw_pkg::STORE_WORDS));
                        n_state  = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                n_eff = merged;
                if (!entry[pgw_pkg::BIT_PRESENT]) begin
                    n_state = S_RESULT;
                end else if (r_level == pgw_pkg::LVL_PDPT && entry[pgw_pkg::BIT_HUGE]) begin
                    n_res_mapped = 1'b1;
                    n_res_pa     = {entry[pgw_pkg::PA_W-1:30], r_va[29:0]};
                    n_res_flags  = merged;
                    n_state      = S_RESULT;
                end else if (r_level == pgw_pkg::LVL_PD && entry[pgw_pkg::BIT_HUGE]) begin
                    n_res_mapped = 1'b1;
                    n_res_pa     = {entry[pgw_pkg::PA_W-1:21], r_va[20:0]};
                    n_res_flags  = merged;
                    n_state      = S_RESULT;
                end else if (r_level == pgw_pkg::LVL_PT) begin
                    n_res_mapped = 1'b1;
                    n_res_pa     = {entry[pgw_pkg::PA_W-1:12], r_va[11:0]};
                    n_res_flags  = merged;
                    n_state      = S_RESULT;
                end else begin
                    // descend: tables beyond the store read as not present
                    ram_en   = 1'b1;
                    ram_addr = word[AW-1:0];
                    n_rd_ok  = (word < pgw_pkg::ENTRY_W'(pgw_pkg::STORE_WORDS));
                    n_level  = r_level + 1'b1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_mapped = r_res_mapped;
                    n_out_pa     = r_res_pa;
                    n_out_flags  = r_res_flags;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_level     <= pgw_pkg::LVL_PML4;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            r_root      <= '0;
            r_enabled   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_level     <= n_level;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pgw_pkg::CFG_ROOT_FRAME: r_root    <= i_cfg_data;
                    pgw_pkg::CFG_ENABLE:     r_enabled <= i_cfg_data[0];
                    default:                 r_root    <= r_root;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_va         <= n_va;
        r_eff        <= n_eff;
        r_res_mapped <= n_res_mapped;
        r_res_pa     <= n_res_pa;
        r_res_flags  <= n_res_flags;
        r_out_mapped <= n_out_mapped;
        r_out_pa     <= n_out_pa;
        r_out_flags  <= n_out_flags;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_mapped;
    assign m_axis_tdata  = {
        (pgw_pkg::M_TDATA_W - pgw_pkg::PA_W - WW)'(0),
        r_out_flags,
        r_out_pa
    };

endmodule

// File: verif/tb_four_level_page_table_walker.sv
// Self-checking testbench for the four-level page-table walker.
// Drives table writes and address walks on the input stream and checks each transfer
// on the output stream against its own walk predictor; depends on pgw_pkg and the RTL.
module tb_four_level_page_table_walker;

    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 125;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIR        = 26;

    typedef enum logic [1:0] {
        ROW_CFG,    // set both registers, block idle
        ROW_ITEM,   // transfer, expectation from the predictor
        ROW_CHK     // transfer, expectation typed in the row
    } t_row_kind;

    typedef struct packed {
        logic        mapped;
        logic [51:0] pa;
        logic [63:0] flags;
    } t_xlat;

    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [47:0] va;
        logic [11:0] widx;
        logic [63:0] wdata;
        logic [2:0]  root;
        logic        en;
        t_xlat       res;
    } t_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_idx = pgw_pkg::CFG_ROOT_FRAME;
    logic [pgw_pkg::ROOT_W-1:0]      i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pgw_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                            s_axis_tuser = pgw_pkg::OP_WALK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pgw_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;

    // Predictor state: table store and register copies
    logic [63:0] tbl_words [pgw_pkg::STORE_WORDS];
    logic [2:0]  root_frame = '0;
    logic        walk_en = 1'b0;

    t_xlat       xlat_q[$];       // translations still owed by the block
    logic [8:0]  idx_pool [4];    // table indices shared by writes and walks in a phase

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold_len = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int n_items = 0;
    int n_results = 0;
    int n_mapped = 0;
    int n_settings = 0;

    four_level_page_table_walker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop: far beyond the slowest legal run, including the store sweep after reset
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_four_level_page_table_walker: FAIL");
            $finish;
        end
    end

    // Directed table. Frames 1..3 form a chain under root frame 0; extra entries
    // exercise huge pages at levels 2 and 3, huge bits that must be ignored at
    // levels 1 and 4, inherited no-execute and read-only, and a table past the store.
    t_row dir_rows [N_DIR] = '{
        // disabled walker: every walk unmapped
        '{ROW_CFG,  pgw_pkg::OP_WALK,  48'h0, 12'd0, 64'h0, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_CHK,  pgw_pkg::OP_WALK,  48'hffff_ffff_ffff, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_CHK,  pgw_pkg::OP_WRITE, 48'h0, 12'd0, 64'hffff_ffff_ffff_ffff, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_CFG,  pgw_pkg::OP_WALK,  48'h0, 12'd0, 64'h0, 3'd0, 1'b1, t_xlat'(0)},
        // root entry points at a frame far beyond the store
        '{ROW_CHK,  pgw_pkg::OP_WALK,  48'h0, 12'd0, 64'h0, 3'd0, 1'b0, t_xlat'(0)},
        // build the 4K chain: root -> frame 1 -> frame 2 -> frame 3 -> leaf
        '{ROW_CHK,  pgw_pkg::OP_WRITE, 48'h0, 12'd0, 64'h1003, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd512, 64'h2003, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd1024, 64'h3003, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd1536, 64'h8000_000f_ffff_f607, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0000_0000_0abc, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // 1G page, read-only, software bits and high bits set
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd513, 64'h7ff0_000f_c000_0681, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0000_7fff_ffff, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // 2M page
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd1026, 64'h0000_000f_ffe0_0683, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0000_005f_ffff, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // huge bit on the root entry: still a table pointer
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd3, 64'h1083, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0180_0000_0123, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // huge bit on the last level: ordinary 4K leaf
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd1540, 64'h5083, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0000_0000_4fff, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // no-execute, read-only root entry taints the whole walk
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd5, 64'h8000_0000_0000_1001, 3'd0, 1'b0,
          t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'h0280_0000_0000, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // level-3 entry points at frame 8, just past the store
        '{ROW_ITEM, pgw_pkg::OP_WRITE, 48'h0, 12'd1031, 64'h8003, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_CHK,  pgw_pkg::OP_WALK,  48'h0000_00e0_0000, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // highest root frame, last store word
        '{ROW_CFG,  pgw_pkg::OP_WALK,  48'h0, 12'd0, 64'h0, 3'd7, 1'b1, t_xlat'(0)},
        '{ROW_CHK,  pgw_pkg::OP_WRITE, 48'h0, 12'd4095, 64'h1003, 3'd0, 1'b0, t_xlat'(0)},
        '{ROW_ITEM, pgw_pkg::OP_WALK,  48'hff80_0000_0000, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)},
        // non-present entry at level 2
        '{ROW_CHK,  pgw_pkg::OP_WALK,  48'hffff_ffff_ffff, 12'd0, 64'h0, 3'd0, 1'b0,
          t_xlat'(0)}
    };

    // Read one table entry; any word outside the store reads as not present.
    function automatic logic [63:0] fetch_entry(logic [39:0] frame, logic [8:0] idx);
        if (frame >= pgw_pkg::STORE_WORDS / pgw_pkg::TABLE_ENTRIES)
            return 64'h0;
        return tbl_words[{frame[2:0], idx}];
    endfunction

    // Translate one virtual address against the predictor's tables and registers.
    function automatic t_xlat translate(logic [47:0] va);
        t_xlat       res;
        logic [39:0] frame;
        logic [63:0] ent;
        logic [63:0] eff;
        logic [8:0]  idx;
        res   = '0;
        eff   = '0;
        frame = {37'd0, root_frame};
        if (!walk_en)
            return res;
        for (int lvl = 0; lvl < 4; lvl++) begin
            idx = va[39 - 9 * lvl +: 9];
            ent = fetch_entry(frame, idx);
            if (!ent[pgw_pkg::BIT_PRESENT])
                return '0;
            if (lvl == 0) begin
                eff = ent;
            end else begin
                if (!eff[pgw_pkg::BIT_WRITABLE])
                    ent[pgw_pkg::BIT_WRITABLE] = 1'b0;
                if (eff[pgw_pkg::BIT_NO_EXEC])
                    ent[pgw_pkg::BIT_NO_EXEC] = 1'b1;
                eff = ent;
            end
            if (lvl == 1 && ent[pgw_pkg::BIT_HUGE]) begin
                res.pa = {ent[51:30], va[29:0]};
                break;
            end
            if (lvl == 2 && ent[pgw_pkg::BIT_HUGE]) begin
                res.pa = {ent[51:21], va[20:0]};
                break;
            end
            if (lvl == 3)
                res.pa = {ent[51:12], va[11:0]};
            frame = ent[51:12];
        end
        res.mapped                         = 1'b1;
        res.flags                          = eff;
        res.flags[pgw_pkg::BIT_SW_TABLE]   = 1'b0;
        res.flags[pgw_pkg::BIT_SW_MAPPING] = 1'b0;
        return res;
    endfunction

    // Random table entry: mostly present, mostly pointing inside the store, some huge.
    function automatic logic [63:0] rand_entry();
        logic [63:0] ent;
        ent = {$urandom, $urandom};
        ent[pgw_pkg::BIT_PRESENT] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 9) != 0)
            ent[51:12] = 40'($urandom_range(0, 7));
        ent[pgw_pkg::BIT_HUGE] = ($urandom_range(0, 3) == 0);
        return ent;
    endfunction

    // Pick a table index: mostly from this phase's pool so walks meet written entries.
    function automatic logic [8:0] pick_idx();
        if ($urandom_range(0, 15) == 0)
            return 9'($urandom);
        return idx_pool[$urandom_range(0, 3)];
    endfunction

    // Offer one item and hold it until the transfer; then log what the block owes.
    task automatic send_item(input logic op, input logic [47:0] va, input logic [11:0] widx,
                             input logic [63:0] wdata, input bit typed, input t_xlat typed_res);
        t_xlat res;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, wdata, widx, va};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == pgw_pkg::OP_WRITE) begin
            tbl_words[widx] = wdata;
            res = '0;
        end else begin
            res = translate(va);
        end
        if (typed)
            res = typed_res;
        xlat_q.push_back(res);
        n_items++;
    endtask

    // Stop offering and wait until every owed result is out, then let the block sit idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (xlat_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back cycles; call only with the block idle.
    task automatic set_config(input logic [2:0] root, input logic en);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pgw_pkg::CFG_ROOT_FRAME;
        i_cfg_data <= root;
        @(posedge i_clk);
        i_cfg_idx  <= pgw_pkg::CFG_ENABLE;
        i_cfg_data <= {{(pgw_pkg::ROOT_W - 1){1'b0}}, en};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        root_frame = root;
        walk_en    = en;
        n_settings++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Checker: compare each output transfer with the oldest owed translation
    always @(posedge i_clk) begin
        t_xlat got;
        t_xlat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mapped = m_axis_tuser;
            got.pa     = m_axis_tdata[51:0];
            got.flags  = m_axis_tdata[115:52];
            n_results++;
            if (xlat_q.size() == 0) begin
                $error("unexpected result transfer: mapped=%0b pa=%h flags=%h",
                       got.mapped, got.pa, got.flags);
                err_cnt++;
            end else begin
                want = xlat_q.pop_front();
                if (want.mapped)
                    n_mapped++;
                if (got.mapped !== want.mapped) begin
                    $error("mapped: expected %0b, got %0b", want.mapped, got.mapped);
                    err_cnt++;
                end
                if (got.pa !== want.pa) begin
                    $error("phys_addr: expected %h, got %h", want.pa, got.pa);
                    err_cnt++;
                end
                if (got.flags !== want.flags) begin
                    $error("page_flags: expected %h, got %h", want.flags, got.flags);
                    err_cnt++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, final drain
    initial begin
        logic [47:0] va;
        logic [11:0] widx;
        int          pick;
        tbl_words = '{default: '0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part; idling on both sides so gaps land on the early walks too
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain();
                set_config(dir_rows[r].root, dir_rows[r].en);
            end else begin
                send_item(dir_rows[r].op, dir_rows[r].va, dir_rows[r].widx, dir_rows[r].wdata,
                          dir_rows[r].kind == ROW_CHK, dir_rows[r].res);
            end
        end

        // Random phases: each builds tables over a small index pool, then mixes
        // walks that follow them with writes, full-range walks and raw writes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            // Leave idling off in every fourth phase and in the closing phases
            tx_idle_on = (ph < NUM_PHASES - 2) && (ph % 4 != 3);
            rx_idle_on = tx_idle_on;
            case (ph)
                0:       set_config(3'd0, 1'b1);
                1:       set_config(3'd7, 1'b1);
                2:       set_config(3'($urandom), 1'b0);
                default: set_config(3'($urandom), $urandom_range(0, 7) != 0);
            endcase
            foreach (idx_pool[p])
                idx_pool[p] = 9'($urandom);
            if (ph % 3 == 0)
                idx_pool[0] = 9'd0;
            if (ph % 3 == 1)
                idx_pool[3] = 9'h1ff;
            // Hold the receiver off long enough for the block to back up its input
            if (ph == 4)
                rx_hold_len = LONG_HOLD;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Pause the sender until every owed result is out
                if (ph == 6 && k == PHASE_ITEMS / 2)
                    drain();
                pick = (k < 24) ? 14 : $urandom_range(0, 19);
                va   = {pick_idx(), pick_idx(), pick_idx(), pick_idx(), 12'($urandom)};
                widx = {3'($urandom), pick_idx()};
                if (pick < 13)
                    send_item(pgw_pkg::OP_WALK, va, 12'($urandom), {$urandom, $urandom},
                              1'b0, '0);
                else if (pick < 17)
                    send_item(pgw_pkg::OP_WRITE, 48'({$urandom, $urandom}), widx, rand_entry(),
                              1'b0, '0);
                else if (pick < 19)
                    send_item(pgw_pkg::OP_WALK, 48'({$urandom, $urandom}), 12'($urandom),
                              {$urandom, $urandom}, 1'b0, '0);
                else
                    send_item(pgw_pkg::OP_WRITE, 48'({$urandom, $urandom}), 12'($urandom),
                              {$urandom, $urandom}, 1'b0, '0);
            end
        end

        drain();
        $display("Sent %0d items (table writes and walks) under %0d register settings;",
                 n_items, n_settings);
        $display("checked %0d results, %0d of them mapped translations.", n_results, n_mapped);
        if (err_cnt == 0 && xlat_q.size() == 0) begin
            $display("tb_four_level_page_table_walker: PASS");
        end else begin
            $display("tb_four_level_page_table_walker: FAIL");
        end
        $finish;
    end

endmodule
